// ----- design/vrdi_pkg.sv -----
// Shared types and constants for the ready-to-drive interlock.
package vrdi_pkg;

  localparam int unsigned PedalW   = 12;
  localparam int unsigned DebW     = 6;
  localparam int unsigned ArmW     = 10;
  localparam int unsigned BuzzW    = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PEDAL_THR = 3'd0,
    REG_SHDN_DEB  = 3'd1,
    REG_ARM_CNT   = 3'd2,
    REG_BUZZ_TKS  = 3'd3,
    REG_FULL_CHK  = 3'd4
  } cfg_reg_e;

  localparam logic [PedalW-1:0] PedalThrRst = 12'd600;
  localparam logic [DebW-1:0]   ShdnDebRst  = 6'd50;
  localparam logic [ArmW-1:0]   ArmCntRst   = 10'd1000;
  localparam logic [BuzzW-1:0]  BuzzTksRst  = 11'd1500;
  localparam logic              FullChkRst  = 1'b1;

  typedef enum logic [1:0] {
    PH_ARM   = 2'd0,
    PH_BUZZ  = 2'd1,
    PH_DRIVE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [PedalW-1:0] pedal_threshold;
    logic [DebW-1:0]   shutdown_debounce;
    logic [ArmW-1:0]   arm_count;
    logic [BuzzW-1:0]  buzzer_ticks;
    logic              full_check_mode;
  } cfg_t;

  typedef struct packed {
    logic [PedalW-1:0] pedal_value;
    logic              brake_pin;
    logic              start_pin;
    logic              shutdown_pin;
  } item_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       buzzer_on;
    logic       brake_light;
    logic       start_led;
    logic       brake_led;
    logic       plausible;
    logic       fault_latched;
    logic       motor_stop;
  } result_t;

endpackage

// ----- design/vrdi_in_if.sv -----
// Poll tick channel: valid/ready with pedal and pin samples.
interface vrdi_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pedal_value;
  logic        brake_pin;
  logic        start_pin;
  logic        shutdown_pin;

  modport source (output valid, pedal_value, brake_pin, start_pin, shutdown_pin,
                  input ready);
  modport sink   (input valid, pedal_value, brake_pin, start_pin, shutdown_pin,
                  output ready);
endinterface

// ----- design/vrdi_out_if.sv -----
// Result channel: valid/ready with phase, indicators and fault outputs.
interface vrdi_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] phase;
  logic       buzzer_on;
  logic       brake_light;
  logic       start_led;
  logic       brake_led;
  logic       plausible;
  logic       fault_latched;
  logic       motor_stop;

  modport source (output valid, phase, buzzer_on, brake_light, start_led, brake_led,
                  plausible, fault_latched, motor_stop, input ready);
  modport sink   (input valid, phase, buzzer_on, brake_light, start_led, brake_led,
                  plausible, fault_latched, motor_stop, output ready);
endinterface

// ----- design/vrdi_cfg_regs.sv -----
// Configuration register file with write-only access.
module vrdi_cfg_regs import vrdi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pedal_threshold   <= PedalThrRst;
      cfg_q.shutdown_debounce <= ShdnDebRst;
      cfg_q.arm_count         <= ArmCntRst;
      cfg_q.buzzer_ticks      <= BuzzTksRst;
      cfg_q.full_check_mode   <= FullChkRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PEDAL_THR: cfg_q.pedal_threshold   <= cfg_data_i[PedalW-1:0];
        REG_SHDN_DEB:  cfg_q.shutdown_debounce <= cfg_data_i[DebW-1:0];
        REG_ARM_CNT:   cfg_q.arm_count         <= cfg_data_i[ArmW-1:0];
        REG_BUZZ_TKS:  cfg_q.buzzer_ticks      <= cfg_data_i[BuzzW-1:0];
        REG_FULL_CHK:  cfg_q.full_check_mode   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/vrdi_ctrl.sv -----
// Interlock state and per-tick next-state and result logic.
module vrdi_ctrl import vrdi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  phase_e           phase_q, phase_d;
  logic [ArmW-1:0]  arm_cnt_q, arm_cnt_d;
  logic [BuzzW-1:0] buzz_cnt_q, buzz_cnt_d;
  logic [DebW-1:0]  open_cnt_q, open_cnt_d;
  logic             plaus_q, plaus_d;
  logic             fault_q, fault_d;

  logic             brake, qual, stop;
  logic [ArmW-1:0]  arm_inc;
  logic [BuzzW-1:0] buzz_inc;
  logic [DebW-1:0]  open_inc;

  assign brake    = ~item_i.brake_pin;
  assign arm_inc  = arm_cnt_q + ArmW'(1);
  assign buzz_inc = buzz_cnt_q + BuzzW'(1);
  assign open_inc = open_cnt_q + DebW'(1);
  assign qual     = cfg_i.full_check_mode ?
                    (item_i.start_pin & brake & item_i.shutdown_pin) : item_i.start_pin;

  // A zero limit acts as one: the nonzero check covers it.
  always_comb begin
    phase_d    = phase_q;
    arm_cnt_d  = arm_cnt_q;
    buzz_cnt_d = buzz_cnt_q;
    open_cnt_d = open_cnt_q;
    plaus_d    = plaus_q;
    fault_d    = fault_q;
    stop       = 1'b0;
    unique case (phase_q)
      PH_DRIVE: begin
        if ((item_i.pedal_value > cfg_i.pedal_threshold) && brake) begin
          plaus_d = 1'b0;
        end else if ((item_i.pedal_value < cfg_i.pedal_threshold) && !brake) begin
          plaus_d = 1'b1;
        end
        if (!item_i.shutdown_pin) begin
          open_cnt_d = open_inc;
          if ((open_inc != '0) && (open_inc >= cfg_i.shutdown_debounce)) begin
            open_cnt_d = '0;
            fault_d    = 1'b1;
            stop       = 1'b1;
            arm_cnt_d  = '0;
            phase_d    = PH_ARM;
          end
        end else begin
          open_cnt_d = '0;
        end
      end
      PH_BUZZ: begin
        buzz_cnt_d = buzz_inc;
        if ((buzz_inc != '0) && (buzz_inc >= cfg_i.buzzer_ticks)) begin
          buzz_cnt_d = '0;
          open_cnt_d = '0;
          phase_d    = PH_DRIVE;
        end
      end
      PH_ARM: begin
        if (qual) begin
          arm_cnt_d = arm_inc;
          if ((arm_inc != '0) && (arm_inc >= cfg_i.arm_count)) begin
            arm_cnt_d  = '0;
            buzz_cnt_d = '0;
            phase_d    = PH_BUZZ;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ARM;
      arm_cnt_q  <= '0;
      buzz_cnt_q <= '0;
      open_cnt_q <= '0;
      plaus_q    <= 1'b1;
      fault_q    <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      arm_cnt_q  <= arm_cnt_d;
      buzz_cnt_q <= buzz_cnt_d;
      open_cnt_q <= open_cnt_d;
      plaus_q    <= plaus_d;
      fault_q    <= fault_d;
    end
  end

  // LEDs follow the pins only when the tick starts and ends in arming.
  always_comb begin
    res_o.phase         = phase_d;
    res_o.buzzer_on     = (phase_d == PH_BUZZ);
    res_o.brake_light   = brake;
    res_o.start_led     = (phase_q == PH_ARM) & (phase_d == PH_ARM) & item_i.start_pin;
    res_o.brake_led     = (phase_q == PH_ARM) & (phase_d == PH_ARM) & brake;
    res_o.plausible     = plaus_d;
    res_o.fault_latched = fault_d;
    res_o.motor_stop    = stop;
  end

endmodule

// ----- design/vehicle_ready_to_drive_interlock.sv -----
// A tick passes through the input register and then the result register before its result is offered.
// One tick per cycle is taken while the result register is empty or its result is being taken by the sink.
// A held result stops the input register from taking the next tick once the input register is full.
// Reset: phase arming, all counters zero, plausible set, fault clear,
// configuration registers at their default values, both pipeline stages empty.
module vehicle_ready_to_drive_interlock import vrdi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  vrdi_in_if.sink             in_if,
  vrdi_out_if.source          out_if
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q;
  result_t res, res_q;
  logic    res_vld_q;
  logic    res_free, step, in_xfer;

  vrdi_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign res_free    = !res_vld_q || out_if.ready;
  assign step        = item_vld_q && res_free;
  assign in_if.ready = !item_vld_q || res_free;
  assign in_xfer     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      item_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.pedal_value  <= in_if.pedal_value;
      item_q.brake_pin    <= in_if.brake_pin;
      item_q.start_pin    <= in_if.start_pin;
      item_q.shutdown_pin <= in_if.shutdown_pin;
    end
  end

  vrdi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_if.valid         = res_vld_q;
  assign out_if.phase         = res_q.phase;
  assign out_if.buzzer_on     = res_q.buzzer_on;
  assign out_if.brake_light   = res_q.brake_light;
  assign out_if.start_led     = res_q.start_led;
  assign out_if.brake_led     = res_q.brake_led;
  assign out_if.plausible     = res_q.plausible;
  assign out_if.fault_latched = res_q.fault_latched;
  assign out_if.motor_stop    = res_q.motor_stop;

endmodule
